// ===== hdl/dctt_pkg.sv =====
// Package for the deadline callback timer table: payload structs, codes, constants.
// No dependencies; used by every module under hdl.
package dctt_pkg;

    localparam int ENTRIES_DEF = 16;

    typedef struct packed {
        logic        cmd;
        logic [39:0] now_ms;
        logic [31:0] interval_ms;
        logic [31:0] handler_id;
        logic [31:0] context_id;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [31:0] fired_handler;
        logic [31:0] fired_context;
        logic [31:0] delay_ms;
        logic        last;
    } t_out;

    localparam logic       CMD_SCHED = 1'b0;
    localparam logic       CMD_RUN   = 1'b1;
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_FIRED  = 2'd1;
    localparam logic [1:0] KIND_DELAY  = 2'd2;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [31:0] DELAY_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] DELAY_NONE = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_INSERT,
        S_EMIT,
        S_REPORT
    } t_state;

endpackage

// ===== hdl/dctt_mem.sv =====
// Timer table storage: one synchronous memory holding handler, context, deadline.
// Depends on dctt_pkg only for the default table depth; the read data is registered.
module dctt_mem #(
    parameter int ENTRIES = dctt_pkg::ENTRIES_DEF,
    parameter int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  logic [104:0]   i_wdata,
    input  logic [AW-1:0]  i_raddr,
    output logic [104:0]   o_rdata
);
    logic [104:0] r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/deadline_callback_timer_table_core.sv =====
// Top level of the deadline callback timer table: sequencer plus table memory.
// Depends on dctt_pkg and dctt_mem.
//
// Every item walks the table once through the single memory read port,
// each entry in two steps (issue the read, then check the entry). A schedule
// that inserts then shifts the kept entries by a read-write walk from the
// tail, reading one entry and writing it one slot higher, and writes the new
// entry at the front. Results wait while the result channel is stalled. Kept
// entries are compacted in place during the walk (write pointer trails read
// pointer), so removal needs no extra pass. The next delay report comes after
// the walk that tracks the minimum remaining deadline. No clearing pass after
// reset.
module deadline_callback_timer_table_core #(
    parameter int ENTRIES = dctt_pkg::ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  dctt_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output dctt_pkg::t_out   o_data
);
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    dctt_pkg::t_state r_state, n_state;
    dctt_pkg::t_in    r_item, n_item;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd, n_rd;      // read pointer
    logic [CW-1:0] r_wr, n_wr;      // compaction write pointer
    logic          r_removed, n_removed;
    logic [40:0]   r_best, n_best;
    logic          r_have, n_have;
    logic          r_ovalid, n_ovalid;
    dctt_pkg::t_out r_out, n_out;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [104:0]  wdata, rdata;

    dctt_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [31:0] e_h, e_c;
    logic [40:0] e_d;
    logic [40:0] now41;
    logic        e_match, e_fire, out_free;
    logic [40:0] dl;

    assign e_h = rdata[104:73];
    assign e_c = rdata[72:41];
    assign e_d = rdata[40:0];
    assign now41 = {1'b0, r_item.now_ms};
    assign e_match = (e_h == r_item.handler_id) && (e_c == r_item.context_id);
    assign e_fire = now41 > e_d;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall = (r_state != dctt_pkg::S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data = r_out;
    assign dl = r_best - now41;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dctt_pkg::S_IDLE;
            r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_item <= n_item;
        r_rd <= n_rd;
        r_wr <= n_wr;
        r_removed <= n_removed;
        r_best <= n_best;
        r_have <= n_have;
        r_out <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_item = r_item;
        n_count = r_count;
        n_rd = r_rd;
        n_wr = r_wr;
        n_removed = r_removed;
        n_best = r_best;
        n_have = r_have;
        n_ovalid = r_ovalid && i_stall;
        n_out = r_out;
        we = 1'b0;
        waddr = r_wr[AW-1:0];
        wdata = rdata;
        raddr = r_rd[AW-1:0];
        unique case (r_state)
            dctt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_item = i_data;
                    n_rd = '0;
                    n_wr = '0;
                    n_removed = 1'b0;
                    n_have = 1'b0;
                    n_state = dctt_pkg::S_READ;
                end
            end
            dctt_pkg::S_READ: begin
                // issue read of entry r_rd
                if (r_rd >= r_count) begin
                    n_count = r_wr;
                    if (r_item.cmd == dctt_pkg::CMD_RUN) begin
                        n_state = dctt_pkg::S_REPORT;
                    end else if (r_item.interval_ms[31] || r_wr >= CW'(ENTRIES)) begin
                        n_state = dctt_pkg::S_EMIT;
                    end else begin
                        // shift from tail: read wr-1, write wr; start in read phase
                        n_rd = r_wr;
                        n_removed = 1'b0;
                        n_state = dctt_pkg::S_INSERT;
                    end
                end else begin
                    n_state = dctt_pkg::S_CHECK;
                end
            end
            dctt_pkg::S_CHECK: begin
                if (r_item.cmd == dctt_pkg::CMD_SCHED) begin
                    if (e_match) begin
                        n_removed = 1'b1;
                    end else begin
                        we = 1'b1;
                        n_wr = r_wr + 1'b1;
                    end
                    n_rd = r_rd + 1'b1;
                    n_state = dctt_pkg::S_READ;
                end else if (e_fire) begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_out = '0;
                        n_out.kind = dctt_pkg::KIND_FIRED;
                        n_out.fired_handler = e_h;
                        n_out.fired_context = e_c;
                        n_rd = r_rd + 1'b1;
                        n_state = dctt_pkg::S_READ;
                    end
                end else begin
                    we = 1'b1;
                    n_wr = r_wr + 1'b1;
                    if (!r_have || e_d < r_best) begin
                        n_best = e_d;
                    end
                    n_have = 1'b1;
                    n_rd = r_rd + 1'b1;
                    n_state = dctt_pkg::S_READ;
                end
            end
            dctt_pkg::S_INSERT: begin
                // r_rd is the slot being filled; data of r_rd-1 arrives in the write phase
                if (r_rd == '0) begin
                    we = 1'b1;
                    waddr = '0;
                    wdata = {r_item.handler_id, r_item.context_id,
                             41'(r_item.now_ms) + 41'({{9{r_item.interval_ms[31]}},
                                                       r_item.interval_ms})};
                    n_count = r_count + 1'b1;
                    n_state = dctt_pkg::S_EMIT;
                end else if (!r_removed) begin
                    // read phase (reuse removed flag as phase bit)
                    raddr = AW'(r_rd - 1'b1);
                    n_removed = 1'b1;
                end else begin
                    we = 1'b1;
                    waddr = r_rd[AW-1:0];
                    n_rd = r_rd - 1'b1;
                    n_removed = 1'b0;
                end
            end
            dctt_pkg::S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out = '0;
                    n_out.kind = dctt_pkg::KIND_STATUS;
                    n_out.last = 1'b1;
                    if (r_item.interval_ms[31]) begin
                        n_out.status = r_removed ? dctt_pkg::ST_OK : dctt_pkg::ST_NOTFOUND;
                    end else if (r_count >= CW'(ENTRIES)) begin
                        n_out.status = (r_state == dctt_pkg::S_EMIT && !r_have)
                                       ? dctt_pkg::ST_FULL : dctt_pkg::ST_OK;
                    end else begin
                        n_out.status = dctt_pkg::ST_OK;
                    end
                    n_state = dctt_pkg::S_IDLE;
                end
            end
            dctt_pkg::S_REPORT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out = '0;
                    n_out.kind = dctt_pkg::KIND_DELAY;
                    n_out.last = 1'b1;
                    if (!r_have) begin
                        n_out.delay_ms = dctt_pkg::DELAY_NONE;
                    end else if (r_best < now41) begin
                        n_out.delay_ms = '0;
                    end else if (dl > 41'(dctt_pkg::DELAY_MAX)) begin
                        n_out.delay_ms = dctt_pkg::DELAY_MAX;
                    end else begin
                        n_out.delay_ms = dl[31:0];
                    end
                    n_state = dctt_pkg::S_IDLE;
                end
            end
            default: n_state = dctt_pkg::S_IDLE;
        endcase
        // insert completion marks "not full" by setting r_have
        if (r_state == dctt_pkg::S_INSERT && r_rd == '0) begin
            n_have = 1'b1;
        end
    end
endmodule

// ===== tb/sv/dctt_checker.sv =====
// Checker for the deadline callback timer table: watches both channels, predicts results
// from a private copy of the timer table and compares them. Depends on dctt_pkg.
module dctt_checker #(
    parameter int ENTRIES = dctt_pkg::ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  dctt_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  dctt_pkg::t_out i_out_data,
    output int             o_errors,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]    tbl_handler [ENTRIES];
    logic [31:0]    tbl_context [ENTRIES];
    logic [40:0]    tbl_deadline[ENTRIES];
    int             tbl_count;
    dctt_pkg::t_out expected_results[$];
    int             errors;

    assign o_errors  = errors;
    assign o_pending = expected_results.size();

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic dctt_pkg::t_out make_result(logic [1:0] kind, logic [1:0] status,
                                                   logic [31:0] fh, logic [31:0] fc,
                                                   logic [31:0] delay, logic last);
        dctt_pkg::t_out r;
        r.kind = kind;
        r.status = status;
        r.fired_handler = fh;
        r.fired_context = fc;
        r.delay_ms = delay;
        r.last = last;
        return r;
    endfunction

    task automatic remove_slot(int idx);
        for (int j = idx; j + 1 < tbl_count; j++) begin
            tbl_handler[j]  = tbl_handler[j+1];
            tbl_context[j]  = tbl_context[j+1];
            tbl_deadline[j] = tbl_deadline[j+1];
        end
        tbl_count--;
    endtask

    task automatic predict_timer(input dctt_pkg::t_in it);
        int          i;
        logic        removed;
        logic [40:0] best;
        logic [40:0] now41;
        logic [40:0] d;
        now41 = {1'b0, it.now_ms};
        if (it.cmd == dctt_pkg::CMD_SCHED) begin
            removed = 1'b0;
            i = 0;
            while (i < tbl_count) begin
                if (tbl_handler[i] == it.handler_id && tbl_context[i] == it.context_id) begin
                    remove_slot(i);
                    removed = 1'b1;
                end else begin
                    i++;
                end
            end
            if (it.interval_ms[31]) begin
                expected_results.push_back(make_result(dctt_pkg::KIND_STATUS,
                    removed ? dctt_pkg::ST_OK : dctt_pkg::ST_NOTFOUND,
                    '0, '0, '0, 1'b1));
            end else if (tbl_count >= ENTRIES) begin
                expected_results.push_back(make_result(dctt_pkg::KIND_STATUS,
                    dctt_pkg::ST_FULL, '0, '0, '0, 1'b1));
            end else begin
                for (int j = tbl_count; j > 0; j--) begin
                    tbl_handler[j]  = tbl_handler[j-1];
                    tbl_context[j]  = tbl_context[j-1];
                    tbl_deadline[j] = tbl_deadline[j-1];
                end
                tbl_handler[0]  = it.handler_id;
                tbl_context[0]  = it.context_id;
                tbl_deadline[0] = now41 + {9'd0, it.interval_ms};
                tbl_count++;
                expected_results.push_back(make_result(dctt_pkg::KIND_STATUS,
                    dctt_pkg::ST_OK, '0, '0, '0, 1'b1));
            end
        end else begin
            i = 0;
            while (i < tbl_count) begin
                if (now41 > tbl_deadline[i]) begin
                    expected_results.push_back(make_result(dctt_pkg::KIND_FIRED,
                        dctt_pkg::ST_OK, tbl_handler[i], tbl_context[i], '0, 1'b0));
                    remove_slot(i);
                end else begin
                    i++;
                end
            end
            if (tbl_count == 0) begin
                expected_results.push_back(make_result(dctt_pkg::KIND_DELAY,
                    dctt_pkg::ST_OK, '0, '0, dctt_pkg::DELAY_NONE, 1'b1));
            end else begin
                best = tbl_deadline[0];
                for (int j = 1; j < tbl_count; j++)
                    if (tbl_deadline[j] < best) best = tbl_deadline[j];
                d = (best >= now41) ? best - now41 : '0;
                if (d > {9'd0, dctt_pkg::DELAY_MAX}) d = {9'd0, dctt_pkg::DELAY_MAX};
                expected_results.push_back(make_result(dctt_pkg::KIND_DELAY,
                    dctt_pkg::ST_OK, '0, '0, d[31:0], 1'b1));
            end
        end
    endtask

    always @(posedge i_clk) begin
        dctt_pkg::t_out exp_r;
        if (!i_rst_n) begin
            tbl_count <= 0;
            errors <= 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) predict_timer(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_out_data.kind !== exp_r.kind)
                        report_mismatch($sformatf("kind %0d exp %0d",
                            i_out_data.kind, exp_r.kind));
                    if (i_out_data.status !== exp_r.status)
                        report_mismatch($sformatf("status %0d exp %0d",
                            i_out_data.status, exp_r.status));
                    if (i_out_data.fired_handler !== exp_r.fired_handler)
                        report_mismatch($sformatf("fired_handler %h exp %h",
                            i_out_data.fired_handler, exp_r.fired_handler));
                    if (i_out_data.fired_context !== exp_r.fired_context)
                        report_mismatch($sformatf("fired_context %h exp %h",
                            i_out_data.fired_context, exp_r.fired_context));
                    if (i_out_data.delay_ms !== exp_r.delay_ms)
                        report_mismatch($sformatf("delay_ms %h exp %h",
                            i_out_data.delay_ms, exp_r.delay_ms));
                    if (i_out_data.last !== exp_r.last)
                        report_mismatch($sformatf("last %b exp %b",
                            i_out_data.last, exp_r.last));
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb.sv =====
// Top of the timer table testbench: clock, reset, stimulus phases with random idling
// and stalls, verdict. Depends on dctt_pkg, dctt_checker and the core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    dctt_pkg::t_in  in_data = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    dctt_pkg::t_out out_data;
    int    errors;
    int    pending;
    int    cycles = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    logic [39:0] now_ms = '0;
    logic [31:0] hpool[4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_5A5A};

    initial begin
        forever #1 clk = ~clk;
    end

    deadline_callback_timer_table_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_data(in_data), .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data)
    );

    dctt_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_in_data(in_data), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_data(out_data), .o_errors(errors), .o_pending(pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one transaction, hold valid until the core no longer stalls, then drop valid.
    task automatic send_item(input dctt_pkg::t_in it);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_cmd(logic cmd, logic [31:0] ival, logic [31:0] h, logic [31:0] c);
        dctt_pkg::t_in it;
        it.cmd = cmd;
        it.now_ms = now_ms;
        it.interval_ms = ival;
        it.handler_id = h;
        it.context_id = c;
        send_item(it);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_interval();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000 | $urandom;
            default: return $urandom_range(60);
        endcase
    endfunction

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0)
                now_ms = now_ms + 40'({$urandom, $urandom} % 64'd5000000000);
            else
                now_ms = now_ms + 40'($urandom_range(25));
            if ($urandom_range(2) == 0)
                send_cmd(dctt_pkg::CMD_RUN, $urandom, $urandom, $urandom);
            else
                send_cmd(dctt_pkg::CMD_SCHED, rand_interval(),
                         ($urandom_range(3) == 0) ? $urandom : hpool[2'($urandom_range(3))],
                         ($urandom_range(3) == 0) ? $urandom : $urandom_range(5));
            if (k == n / 2) drain();
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty run, cancel miss, fill past capacity, reschedule, cancel hit, long delay.
        send_cmd(dctt_pkg::CMD_RUN, '0, '0, '0);
        send_cmd(dctt_pkg::CMD_SCHED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int k = 0; k < 17; k++)
            send_cmd(dctt_pkg::CMD_SCHED, 32'(k * 3), 32'(k), 32'hFFFF_FFFF - 32'(k));
        send_cmd(dctt_pkg::CMD_SCHED, 32'd5, 32'd3, 32'hFFFF_FFFC);
        send_cmd(dctt_pkg::CMD_SCHED, 32'h8000_0000, 32'd4, 32'hFFFF_FFFB);
        now_ms = 40'd20;
        send_cmd(dctt_pkg::CMD_RUN, '0, '0, '0);
        send_cmd(dctt_pkg::CMD_SCHED, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        now_ms = 40'hFF_FFFF_FFFF;
        send_cmd(dctt_pkg::CMD_RUN, '0, '0, '0);
        now_ms = 40'h7F_FFFF_FFFF;
        send_cmd(dctt_pkg::CMD_RUN, '0, '0, '0);
        drain();

        random_phase(36, 0, 0);
        random_phase(36, 76, 0);
        random_phase(36, 0, 76);
        random_phase(36, 25, 25);

        recv_stall_pct = 0;
        drain();
        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
